// File: src/brcr_pkg.sv
// Package for the block read cache tag and slot manager.
// Holds the request and result word types, their codes and the default sizes.
// No dependencies.
package brcr_pkg;

  localparam int BLOCK_BYTES_DEF  = 4096;
  localparam int STORE_BLOCKS_DEF = 2048;
  localparam int CACHE_SLOTS_DEF  = 512;

  localparam int MAX_RESULTS = 17;
  localparam int N_W         = 5;
  localparam int BLK_W       = 18;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_INVAL = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_MISS   = 2'd1,
    KIND_BYPASS = 2'd2,
    KIND_INVAL  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] start_block;
    logic [19:0] byte_offset;
    logic [15:0] byte_count;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] block_no;
    logic [8:0]  slot;
    logic [11:0] offset_in_block;
    logic [15:0] piece_bytes;
    logic        last;
  } rsp_t;

endpackage

// File: src/brcr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module brcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/brcr_rem.sv
// Remainder of a word by a constant divisor, used to pick a victim slot.
// A power-of-two divisor gives a registered mask of the low bits; otherwise the result of a
// reciprocal multiplication is registered and then one correcting subtraction is registered. Depends on brcr_pkg.
module brcr_rem
  import brcr_pkg::*;
#(
  parameter int WIDTH   = 16,
  parameter int DIVISOR = CACHE_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [WIDTH-1:0]           value,
  output logic                       done,
  output logic [$clog2(DIVISOR)-1:0] rem
);

  localparam int  RW      = $clog2(DIVISOR);
  localparam bit  IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;

  generate
    if (IS_POW2) begin : g_mask
      logic [RW-1:0] acc;

      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= go;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          acc <= value[RW-1:0];
        end
      end

      assign rem = acc;
    end else begin : g_recip
      localparam int          PW    = WIDTH + 32;
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIVISOR);

      logic [WIDTH-1:0] val;
      logic [WIDTH-1:0] quo;
      logic [PW-1:0]    prod;
      logic [WIDTH-1:0] part;
      logic [WIDTH-1:0] fixed;
      logic [RW-1:0]    acc;
      logic             run;

      // The estimated quotient is at most one below the true one.
      assign prod  = PW'(value) * PW'(RECIP);
      assign part  = val - WIDTH'(quo * DIVISOR);
      assign fixed = (part >= WIDTH'(DIVISOR)) ? part - WIDTH'(DIVISOR) : part;

      always_ff @(posedge clk) begin
        if (rst) begin
          run  <= 1'b0;
          done <= 1'b0;
        end else begin
          run  <= go;
          done <= run;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          val <= value;
          quo <= prod[PW-1:32];
        end
        if (run) begin
          acc <= fixed[RW-1:0];
        end
      end

      assign rem = acc;
    end
  endgenerate

endmodule

// File: src/block_read_cache_random_replace_top.sv
// Top level of the block read cache tag and slot manager.
// Depends on brcr_pkg, brcr_ram and brcr_rem.
//
// A request is taken when start is high and busy is low; every result word appears on rsp for
// exactly one cycle with rsp_valid high and cannot be held off. After reset the block runs a
// clearing pass over every entry of both maps with busy high. The block to slot map is read
// once per block: each block of a read passes S_STEP and S_B2S and ends there on a hit; a miss
// into a free slot goes on to S_MAP, and a miss that replaces a slot goes through S_REM for the
// victim remainder and then S_S2B before S_MAP. A bypass word or an empty read ends in S_STEP.
// An invalidate passes S_STEP and S_INV for each block walked, and gives one word of result.
module block_read_cache_random_replace_top
  import brcr_pkg::*;
#(
  parameter int BLOCK_BYTES  = BLOCK_BYTES_DEF,
  parameter int STORE_BLOCKS = STORE_BLOCKS_DEF,
  parameter int CACHE_SLOTS  = CACHE_SLOTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int RM_W  = OFF_W + 1;
  localparam int B_AW  = $clog2(STORE_BLOCKS);
  localparam int S_AW  = $clog2(CACHE_SLOTS);
  localparam int SU_W  = $clog2(CACHE_SLOTS + 1);
  localparam int MAXD  = (STORE_BLOCKS > CACHE_SLOTS) ? STORE_BLOCKS : CACHE_SLOTS;
  localparam int CLR_W = $clog2(MAXD);
  localparam int B2S_W = S_AW + 1;
  localparam int S2B_W = B_AW + 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_STEP  = 8'b0000_0100,
    S_B2S   = 8'b0000_1000,
    S_REM   = 8'b0001_0000,
    S_S2B   = 8'b0010_0000,
    S_MAP   = 8'b0100_0000,
    S_INV   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [CLR_W-1:0] clr;
  logic [SU_W-1:0]  slots_used;
  logic [15:0]      lfsr;
  logic [15:0]      lfsr_next;
  logic [N_W-1:0]   n;

  cmd_t             cmd;
  logic [BLK_W-1:0] blk;
  logic [OFF_W-1:0] off;
  logic [15:0]      cnt;
  logic [S_AW-1:0]  slot;
  logic [15:0]      first_blk;
  logic [11:0]      first_off;
  logic [15:0]      first_cnt;

  logic             b2s_we, s2b_we;
  logic [B_AW-1:0]  b2s_waddr;
  logic [S_AW-1:0]  s2b_waddr;
  logic [B2S_W-1:0] b2s_wdata, b2s_rdata;
  logic [S2B_W-1:0] s2b_wdata, s2b_rdata;

  logic             rem_go, rem_done;
  logic [S_AW-1:0]  rem_out;

  logic             accept, emit, adv, alloc_seq, alloc_rand;
  rsp_t             emit_word;
  logic [BLK_W-1:0] nblk;
  logic [RM_W-1:0]  room;
  logic [16:0]      take;
  logic [15:0]      cnt_after;
  logic             in_range, last_now, clr_end;

  assign busy      = state != S_IDLE;
  assign accept    = start && !busy;
  assign nblk      = BLK_W'(req.start_block) + BLK_W'(req.byte_offset >> OFF_W);
  assign room      = RM_W'(BLOCK_BYTES) - {1'b0, off};
  assign take      = (17'(room) < {1'b0, cnt}) ? 17'(room) : {1'b0, cnt};
  assign cnt_after = cnt - take[15:0];
  assign in_range  = blk < BLK_W'(STORE_BLOCKS);
  assign last_now  = (cnt_after == '0) || (n == N_W'(MAX_RESULTS - 1));
  assign clr_end   = {1'b0, clr} == (CLR_W + 1)'(MAXD - 1);
  assign lfsr_next = {1'b0, lfsr[15:1]} ^ (lfsr[0] ? LFSR_TAPS : 16'h0000);
  assign rem_go    = alloc_rand;

  brcr_ram #(.WIDTH(B2S_W), .DEPTH(STORE_BLOCKS)) u_b2s (
    .clk   (clk),
    .we    (b2s_we),
    .waddr (b2s_waddr),
    .wdata (b2s_wdata),
    .raddr (blk[B_AW-1:0]),
    .rdata (b2s_rdata)
  );

  brcr_ram #(.WIDTH(S2B_W), .DEPTH(CACHE_SLOTS)) u_s2b (
    .clk   (clk),
    .we    (s2b_we),
    .waddr (s2b_waddr),
    .wdata (s2b_wdata),
    .raddr (rem_out),
    .rdata (s2b_rdata)
  );

  brcr_rem #(.WIDTH(16), .DIVISOR(CACHE_SLOTS)) u_rem (
    .clk   (clk),
    .rst   (rst),
    .go    (rem_go),
    .value (lfsr_next),
    .done  (rem_done),
    .rem   (rem_out)
  );

  always_comb begin
    state_next = state;
    b2s_we     = 1'b0;
    b2s_waddr  = blk[B_AW-1:0];
    b2s_wdata  = '0;
    s2b_we     = 1'b0;
    s2b_waddr  = slot;
    s2b_wdata  = '0;
    emit       = 1'b0;
    adv        = 1'b0;
    alloc_seq  = 1'b0;
    alloc_rand = 1'b0;
    emit_word.kind            = KIND_HIT;
    emit_word.block_no        = blk[15:0];
    emit_word.slot            = '0;
    emit_word.offset_in_block = 12'(off);
    emit_word.piece_bytes     = take[15:0];
    emit_word.last            = last_now;
    case (state)
      S_CLEAR: begin
        b2s_we    = {1'b0, clr} < (CLR_W + 1)'(STORE_BLOCKS);
        b2s_waddr = clr[B_AW-1:0];
        s2b_we    = {1'b0, clr} < (CLR_W + 1)'(CACHE_SLOTS);
        s2b_waddr = clr[S_AW-1:0];
        if (clr_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        if (cmd == CMD_INVAL) begin
          if (slots_used == '0 || cnt == '0 || !in_range) begin
            emit                      = 1'b1;
            emit_word.kind            = KIND_INVAL;
            emit_word.block_no        = first_blk;
            emit_word.offset_in_block = first_off;
            emit_word.piece_bytes     = first_cnt;
            emit_word.last            = 1'b1;
            state_next                = S_IDLE;
          end else begin
            state_next = S_INV;
          end
        end else if (cnt == '0) begin
          state_next = S_IDLE;
        end else if (!in_range) begin
          emit                  = 1'b1;
          emit_word.kind        = KIND_BYPASS;
          emit_word.piece_bytes = cnt;
          emit_word.last        = 1'b1;
          state_next            = S_IDLE;
        end else begin
          state_next = S_B2S;
        end
      end
      S_B2S: begin
        if (b2s_rdata[S_AW]) begin
          emit           = 1'b1;
          adv            = 1'b1;
          emit_word.kind = KIND_HIT;
          emit_word.slot = 9'(b2s_rdata[S_AW-1:0]);
          state_next     = last_now ? S_IDLE : S_STEP;
        end else if (slots_used < SU_W'(CACHE_SLOTS)) begin
          alloc_seq  = 1'b1;
          state_next = S_MAP;
        end else begin
          alloc_rand = 1'b1;
          state_next = S_REM;
        end
      end
      S_REM: begin
        if (rem_done) begin
          state_next = S_S2B;
        end
      end
      S_S2B: begin
        b2s_we     = s2b_rdata[B_AW];
        b2s_waddr  = s2b_rdata[B_AW-1:0];
        state_next = S_MAP;
      end
      S_MAP: begin
        b2s_we         = 1'b1;
        b2s_wdata      = {1'b1, slot};
        s2b_we         = 1'b1;
        s2b_wdata      = {1'b1, blk[B_AW-1:0]};
        emit           = 1'b1;
        adv            = 1'b1;
        emit_word.kind = KIND_MISS;
        emit_word.slot = 9'(slot);
        state_next     = last_now ? S_IDLE : S_STEP;
      end
      S_INV: begin
        b2s_we     = b2s_rdata[S_AW];
        s2b_we     = b2s_rdata[S_AW];
        s2b_waddr  = b2s_rdata[S_AW-1:0];
        adv        = 1'b1;
        state_next = S_STEP;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr        <= '0;
      slots_used <= '0;
      lfsr       <= LFSR_SEED;
      n          <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= emit;
      if (state == S_CLEAR) begin
        clr <= clr + 1'b1;
      end
      if (alloc_seq) begin
        slots_used <= slots_used + 1'b1;
      end
      if (alloc_rand) begin
        lfsr <= lfsr_next;
      end
      if (accept) begin
        n <= '0;
      end else if (emit) begin
        n <= n + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= req.cmd;
      blk       <= nblk;
      off       <= req.byte_offset[OFF_W-1:0];
      cnt       <= req.byte_count;
      first_blk <= nblk[15:0];
      first_off <= 12'(req.byte_offset[OFF_W-1:0]);
      first_cnt <= req.byte_count;
    end else if (adv) begin
      cnt <= cnt_after;
      off <= '0;
      blk <= blk + 1'b1;
    end
    if (alloc_seq) begin
      slot <= slots_used[S_AW-1:0];
    end else if (state == S_REM && rem_done) begin
      slot <= rem_out;
    end
    if (emit) begin
      rsp <= emit_word;
    end
  end

  ap_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("State register is not one-hot.");

  ap_slots_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= SU_W'(CACHE_SLOTS))
    else $error("More slots handed out than the cache holds.");

  ap_lfsr_live: assert property (@(posedge clk) disable iff (rst) lfsr != 16'h0000)
    else $error("Victim LFSR has locked up at zero.");

  ap_miss_mapped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind == KIND_MISS) |-> $past(state == S_MAP))
    else $error("Miss word issued without the maps being written.");

  ap_accept_walk: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_STEP)
    else $error("Accepted request did not start its block walk.");

endmodule
